### design/lbmc_pkg.sv
// Shared types, constants and helper functions for the lamp button mode controller.
`timescale 1ns / 1ps
`default_nettype none

package lbmc_pkg;

    // Clock and press timing constants.
    localparam int TICKS_PER_SECOND   = 100;
    localparam int BLINK_TICKS        = 20;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int PRESS_MAX          = 60;
    localparam int LEVEL_MAX          = 255;
    localparam int TICK_MAX           = 127;

    localparam logic [6:0] TICK_LIMIT   = 7'(TICKS_PER_SECOND);
    localparam logic [5:0] SECOND_LIMIT = 6'(SECONDS_PER_MINUTE);
    localparam logic [5:0] PRESS_LIMIT  = 6'(PRESS_MAX);
    localparam logic [7:0] LEVEL_FULL   = 8'(LEVEL_MAX);
    localparam logic [7:0] COUNT_FULL   = 8'hFF;

    // Item kinds.
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Mode codes shared by the light and sleep mode cycles.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_SECOND = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MIN_SHORT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MIN_LONG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LONG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LONG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_STEP      = 3'd4;
    localparam int CFG_DATA_W = 8;

    // Input word.
    typedef struct packed {
        logic cmd;
        logic power_pressed;
        logic light_pressed;
        logic sleep_pressed;
    } lbmc_in_t;

    // Result word.
    typedef struct packed {
        logic       power_on;
        logic [1:0] light_mode;
        logic [1:0] sleep_mode;
        logic [7:0] brightness;
        logic       ramp_up;
        logic       status_light;
        logic       radio_request;
        logic       auto_off;
    } lbmc_out_t;

    // Configuration registers.
    typedef struct packed {
        logic [7:0] off_minutes_short;
        logic [7:0] off_minutes_long;
        logic [5:0] power_long_press;
        logic [7:0] light_long_press;
        logic [7:0] dim_step;
    } lbmc_cfg_t;

    // Controller state.
    typedef struct packed {
        logic       power_held;
        logic [5:0] power_count;
        logic       light_held;
        logic [7:0] light_count;
        logic       sleep_held;
        logic [5:0] sleep_count;
        logic       power_state;
        logic [1:0] light_state;
        logic [1:0] sleep_state;
        logic [7:0] level;
        logic       direction;
        logic [6:0] tick_count;
        logic [5:0] second_count;
        logic [7:0] minute_count;
        logic       blink;
    } lbmc_state_t;

    // Controller state after reset: everything clear, brightness at full.
    localparam lbmc_state_t STATE_RESET = '{
        power_held:   1'b0,
        power_count:  6'd0,
        light_held:   1'b0,
        light_count:  8'd0,
        sleep_held:   1'b0,
        sleep_count:  6'd0,
        power_state:  1'b0,
        light_state:  MODE_OFF,
        sleep_state:  MODE_OFF,
        level:        LEVEL_FULL,
        direction:    1'b0,
        tick_count:   7'd0,
        second_count: 6'd0,
        minute_count: 8'd0,
        blink:        1'b0
    };

    // True when the tick count is a multiple of the blink period.
    function automatic logic blink_due(input logic [6:0] t);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= TICK_MAX / BLINK_TICKS; k++)
        begin
            if (t == 7'(k * BLINK_TICKS))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Advance a mode through off, first, second and back to off.
    function automatic logic [1:0] next_mode(input logic [1:0] m);
        logic [1:0] r;
        r = (m >= MODE_SECOND) ? MODE_OFF : m + 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

### design/lamp_button_mode_controller_top.sv
// Top level of the lamp button mode controller: input register, state and result register.
// The input and result registers each hold one word, with the step logic between them.
// Throughput: one word per cycle while the result side is not stalled.
// The combinational state update in the step logic sets this rate.
// Reset clears all state, sets brightness to full and loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none

module lamp_button_mode_controller_top
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   item_valid,
    output logic                                  item_stall,
    input  wire lbmc_pkg::lbmc_in_t               item,
    output logic                                  result_valid,
    input  wire                                   result_stall,
    output lbmc_pkg::lbmc_out_t                   result,
    input  wire                                   cfg_we,
    input  wire [lbmc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [lbmc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    lbmc_pkg::lbmc_cfg_t   cfg_reg;
    lbmc_pkg::lbmc_state_t state_reg;
    lbmc_pkg::lbmc_state_t state_next;
    lbmc_pkg::lbmc_in_t    item_reg;
    logic                  item_valid_reg;
    lbmc_pkg::lbmc_out_t   result_reg;
    lbmc_pkg::lbmc_out_t   result_next;
    logic                  result_valid_reg;
    logic                  result_free;
    logic                  advance;

    // Handshake control.
    assign result_free  = !result_valid_reg || !result_stall;
    assign advance      = item_valid_reg && result_free;
    assign item_stall   = item_valid_reg && !result_free;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_minutes_short <= 8'd5;
            cfg_reg.off_minutes_long  <= 8'd10;
            cfg_reg.power_long_press  <= 6'd20;
            cfg_reg.light_long_press  <= 8'd10;
            cfg_reg.dim_step          <= 8'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbmc_pkg::CFG_OFF_MIN_SHORT: cfg_reg.off_minutes_short <= cfg_data;
                lbmc_pkg::CFG_OFF_MIN_LONG:  cfg_reg.off_minutes_long  <= cfg_data;
                lbmc_pkg::CFG_POWER_LONG:    cfg_reg.power_long_press  <= cfg_data[5:0];
                lbmc_pkg::CFG_LIGHT_LONG:    cfg_reg.light_long_press  <= cfg_data;
                lbmc_pkg::CFG_DIM_STEP:      cfg_reg.dim_step          <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register: loads whenever it is empty or passing its word on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
    end

    // State update for the word in the input register.
    lbmc_step u_step
    (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbmc_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_free)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // A stalled word in the input register stays put.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !result_free |=> item_valid_reg && $stable(item_reg))
        else $error("input register changed while stalled");

    // A timer expiry leaves every mode off.
    a_auto_off_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.auto_off |->
            !result_reg.power_on && result_reg.light_mode == lbmc_pkg::MODE_OFF &&
            result_reg.sleep_mode == lbmc_pkg::MODE_OFF)
        else $error("auto off left a mode active");

    // Radio request and auto off come from different word kinds.
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.radio_request && result_reg.auto_off))
        else $error("radio request and auto off in one word");

    // State changes only when a word is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a word");

    // Mode codes never reach the unused value.
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.light_state != 2'd3 && state_reg.sleep_state != 2'd3)
        else $error("mode state out of range");

endmodule

`default_nettype wire

### design/lbmc_step.sv
// Next-state and result logic for one tick or button sample word.
`timescale 1ns / 1ps
`default_nettype none

module lbmc_step
(
    input  wire lbmc_pkg::lbmc_state_t state,
    input  wire lbmc_pkg::lbmc_cfg_t   cfg,
    input  wire lbmc_pkg::lbmc_in_t    item,
    output lbmc_pkg::lbmc_state_t      state_next,
    output lbmc_pkg::lbmc_out_t        result
);

    lbmc_pkg::lbmc_state_t s;
    logic                  radio;
    logic                  fired;
    logic                  lit;
    logic [8:0]            level_sum;

    always_comb
    begin
        s         = state;
        radio     = 1'b0;
        fired     = 1'b0;
        lit       = 1'b0;
        level_sum = '0;

        if (item.cmd == lbmc_pkg::CMD_TICK)
        begin
            // Tick, second and minute clock with the status blink.
            s.tick_count = state.tick_count + 7'd1;
            if (lbmc_pkg::blink_due(s.tick_count))
            begin
                s.blink = ~state.blink;
            end
            if (s.tick_count >= lbmc_pkg::TICK_LIMIT)
            begin
                s.second_count = state.second_count + 6'd1;
                s.tick_count   = '0;
            end
            if (s.second_count >= lbmc_pkg::SECOND_LIMIT)
            begin
                s.minute_count = state.minute_count + 8'd1;
                s.second_count = '0;
            end
            // Sleep timer expiry switches everything off.
            if (s.power_state &&
                ((s.sleep_state == lbmc_pkg::MODE_FIRST &&
                  s.minute_count == cfg.off_minutes_short) ||
                 (s.sleep_state == lbmc_pkg::MODE_SECOND &&
                  s.minute_count == cfg.off_minutes_long)))
            begin
                s.power_state = 1'b0;
                s.light_state = lbmc_pkg::MODE_OFF;
                s.sleep_state = lbmc_pkg::MODE_OFF;
                fired         = 1'b1;
            end
            // The status light rests when nothing is active.
            if (!s.power_state && s.light_state == lbmc_pkg::MODE_OFF &&
                s.sleep_state == lbmc_pkg::MODE_OFF)
            begin
                s.blink = 1'b0;
            end
        end
        else
        begin
            // Power button: time the press, act on release.
            if (item.power_pressed)
            begin
                if (!state.power_held)
                begin
                    s.power_held  = 1'b1;
                    s.power_count = '0;
                end
                else if (state.power_count < lbmc_pkg::PRESS_LIMIT)
                begin
                    s.power_count = state.power_count + 6'd1;
                end
            end
            else
            begin
                s.power_held = 1'b0;
                if (state.power_count != '0)
                begin
                    if (state.power_count >= cfg.power_long_press)
                    begin
                        radio = state.power_state;
                    end
                    else if (!state.power_state)
                    begin
                        s.power_state = 1'b1;
                        s.light_state = lbmc_pkg::MODE_FIRST;
                        s.level       = lbmc_pkg::LEVEL_FULL;
                    end
                    else
                    begin
                        s.power_state = 1'b0;
                        s.light_state = lbmc_pkg::MODE_OFF;
                        s.sleep_state = lbmc_pkg::MODE_OFF;
                    end
                end
                s.power_count = '0;
            end

            // Light button: ramp while held, mode or direction on release.
            lit = (s.light_state == lbmc_pkg::MODE_FIRST) ||
                  (s.light_state == lbmc_pkg::MODE_SECOND);
            if (item.light_pressed)
            begin
                if (!state.light_held)
                begin
                    s.light_held  = 1'b1;
                    s.light_count = '0;
                end
                else
                begin
                    if (state.light_count != lbmc_pkg::COUNT_FULL)
                    begin
                        s.light_count = state.light_count + 8'd1;
                    end
                    if (lit)
                    begin
                        if (!state.direction)
                        begin
                            s.level = (s.level > cfg.dim_step) ?
                                      s.level - cfg.dim_step : 8'd0;
                        end
                        else
                        begin
                            // The level may have just been set by the power button.
                            level_sum = {1'b0, s.level} + {1'b0, cfg.dim_step};
                            s.level = level_sum[8] ? lbmc_pkg::LEVEL_FULL :
                                      level_sum[7:0];
                        end
                    end
                end
            end
            else
            begin
                s.light_held = 1'b0;
                if (state.light_count != '0)
                begin
                    if (state.light_count > cfg.light_long_press)
                    begin
                        if (lit)
                        begin
                            s.direction = ~state.direction;
                        end
                    end
                    else if (s.power_state)
                    begin
                        s.light_state = lbmc_pkg::next_mode(s.light_state);
                    end
                end
                s.light_count = '0;
            end

            // Sleep button: cycle the timer and restart the clock on release.
            if (item.sleep_pressed)
            begin
                if (!state.sleep_held)
                begin
                    s.sleep_held  = 1'b1;
                    s.sleep_count = '0;
                end
                else if (state.sleep_count < lbmc_pkg::PRESS_LIMIT)
                begin
                    s.sleep_count = state.sleep_count + 6'd1;
                end
            end
            else
            begin
                s.sleep_held = 1'b0;
                if (state.sleep_count != '0 && s.power_state)
                begin
                    s.tick_count   = '0;
                    s.second_count = '0;
                    s.minute_count = '0;
                    s.sleep_state  = lbmc_pkg::next_mode(s.sleep_state);
                end
                s.sleep_count = '0;
            end
        end
    end

    // Result word taken from the updated state.
    assign state_next           = s;
    assign result.power_on      = s.power_state;
    assign result.light_mode    = s.light_state;
    assign result.sleep_mode    = s.sleep_state;
    assign result.brightness    = s.level;
    assign result.ramp_up       = s.direction;
    assign result.status_light  = s.blink;
    assign result.radio_request = radio;
    assign result.auto_off      = fired;

endmodule

`default_nettype wire

### verif/lamp_panel_checker.sv
// Checker for the lamp panel: predicts every result word and compares it with the block's output.
`timescale 1ns / 1ps

module lamp_panel_checker
    import lbmc_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    item_valid,
    input  wire                    item_stall,
    input  lbmc_in_t               item,
    input  wire                    result_valid,
    input  wire                    result_stall,
    input  lbmc_out_t              result,
    input  wire                    cfg_we,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data,
    output int                     mismatches,
    output int                     awaiting,
    output logic                   lamp_is_on
);

    localparam int         TICKS_PER_SEC = 100;
    localparam int         BLINK_PERIOD  = 20;
    localparam int         SECS_PER_MIN  = 60;
    localparam logic [5:0] PRESS_CAP     = 6'd60;
    localparam logic [7:0] FULL_LEVEL    = 8'hFF;

    // Settings of the panel as last written.
    logic [7:0] min_short;
    logic [7:0] min_long;
    logic [5:0] press_long;
    logic [7:0] light_long;
    logic [7:0] step;

    // Button timing, modes, dimmer and clock.
    logic       pwr_held;
    logic [5:0] pwr_cnt;
    logic       lgt_held;
    logic [7:0] lgt_cnt;
    logic       slp_held;
    logic [5:0] slp_cnt;
    logic       pwr_on;
    logic [1:0] lgt_mode;
    logic [1:0] slp_mode;
    logic [7:0] level;
    logic       up;
    logic [6:0] ticks;
    logic [5:0] secs;
    logic [7:0] mins;
    logic       blink;

    lbmc_out_t  expected_q[$];
    lbmc_out_t  want_word;
    lbmc_out_t  next_word;
    int         fail_count = 0;
    int         word_no = 0;

    assign mismatches = fail_count;

    // Modes step off, first, second and back to off.
    function automatic logic [1:0] cycle_mode(input logic [1:0] m);
        return (m >= MODE_SECOND) ? MODE_OFF : m + 2'd1;
    endfunction

    task automatic switch_all_off();
        pwr_on   = 1'b0;
        lgt_mode = MODE_OFF;
        slp_mode = MODE_OFF;
    endtask

    // Work out the panel state after one word and the result word it gives.
    task automatic predict_word(input lbmc_in_t w, output lbmc_out_t r);
        logic       fired;
        logic       radio;
        logic       lit;
        logic [8:0] sum;
        fired = 1'b0;
        radio = 1'b0;
        if (w.cmd == CMD_TICK)
        begin
            // Time tick: clock, status blink and sleep timer.
            ticks = ticks + 7'd1;
            if (ticks % BLINK_PERIOD == 0)
            begin
                blink = ~blink;
            end
            if (ticks >= TICKS_PER_SEC)
            begin
                secs  = secs + 6'd1;
                ticks = '0;
            end
            if (secs >= SECS_PER_MIN)
            begin
                mins = mins + 8'd1;
                secs = '0;
            end
            if (pwr_on && ((slp_mode == MODE_FIRST && mins == min_short) ||
                           (slp_mode == MODE_SECOND && mins == min_long)))
            begin
                switch_all_off();
                fired = 1'b1;
            end
            if (!pwr_on && lgt_mode == MODE_OFF && slp_mode == MODE_OFF)
            begin
                blink = 1'b0;
            end
        end
        else
        begin
            // Power button acts on release: toggle on a short press, radio on a long one.
            if (w.power_pressed)
            begin
                if (!pwr_held)
                begin
                    pwr_held = 1'b1;
                    pwr_cnt  = '0;
                end
                else if (pwr_cnt < PRESS_CAP)
                begin
                    pwr_cnt = pwr_cnt + 6'd1;
                end
            end
            else
            begin
                pwr_held = 1'b0;
                if (pwr_cnt != 0)
                begin
                    if (pwr_cnt >= press_long)
                    begin
                        radio = pwr_on;
                    end
                    else if (!pwr_on)
                    begin
                        pwr_on   = 1'b1;
                        lgt_mode = MODE_FIRST;
                        level    = FULL_LEVEL;
                    end
                    else
                    begin
                        switch_all_off();
                    end
                end
                pwr_cnt = '0;
            end

            // Light button ramps the level while held and acts on release.
            lit = (lgt_mode == MODE_FIRST || lgt_mode == MODE_SECOND);
            if (w.light_pressed)
            begin
                if (!lgt_held)
                begin
                    lgt_held = 1'b1;
                    lgt_cnt  = '0;
                end
                else
                begin
                    if (lgt_cnt != 8'hFF)
                    begin
                        lgt_cnt = lgt_cnt + 8'd1;
                    end
                    if (lit)
                    begin
                        if (!up)
                        begin
                            level = (level > step) ? level - step : 8'd0;
                        end
                        else
                        begin
                            sum   = {1'b0, level} + {1'b0, step};
                            level = (sum > 9'(FULL_LEVEL)) ? FULL_LEVEL : sum[7:0];
                        end
                    end
                end
            end
            else
            begin
                lgt_held = 1'b0;
                if (lgt_cnt != 0)
                begin
                    if (lgt_cnt > light_long)
                    begin
                        if (lit)
                        begin
                            up = ~up;
                        end
                    end
                    else if (pwr_on)
                    begin
                        lgt_mode = cycle_mode(lgt_mode);
                    end
                end
                lgt_cnt = '0;
            end

            // Sleep button cycles the timer and restarts the clock.
            if (w.sleep_pressed)
            begin
                if (!slp_held)
                begin
                    slp_held = 1'b1;
                    slp_cnt  = '0;
                end
                else if (slp_cnt < PRESS_CAP)
                begin
                    slp_cnt = slp_cnt + 6'd1;
                end
            end
            else
            begin
                slp_held = 1'b0;
                if (slp_cnt != 0 && pwr_on)
                begin
                    ticks    = '0;
                    secs     = '0;
                    mins     = '0;
                    slp_mode = cycle_mode(slp_mode);
                end
                slp_cnt = '0;
            end
        end
        r.power_on      = pwr_on;
        r.light_mode    = lgt_mode;
        r.sleep_mode    = slp_mode;
        r.brightness    = level;
        r.ramp_up       = up;
        r.status_light  = blink;
        r.radio_request = radio;
        r.auto_off      = fired;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result word %0d: %s", $time, word_no, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Watch both channels and the register port at every edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_short  = 8'd5;
            min_long   = 8'd10;
            press_long = 6'd20;
            light_long = 8'd10;
            step       = 8'd5;
            pwr_held   = 1'b0;
            pwr_cnt    = '0;
            lgt_held   = 1'b0;
            lgt_cnt    = '0;
            slp_held   = 1'b0;
            slp_cnt    = '0;
            pwr_on     = 1'b0;
            lgt_mode   = MODE_OFF;
            slp_mode   = MODE_OFF;
            level      = FULL_LEVEL;
            up         = 1'b0;
            ticks      = '0;
            secs       = '0;
            mins       = '0;
            blink      = 1'b0;
            expected_q.delete();
            awaiting   <= 0;
            lamp_is_on <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OFF_MIN_SHORT: min_short  = cfg_data;
                    CFG_OFF_MIN_LONG:  min_long   = cfg_data;
                    CFG_POWER_LONG:    press_long = cfg_data[5:0];
                    CFG_LIGHT_LONG:    light_long = cfg_data;
                    CFG_DIM_STEP:      step       = cfg_data;
                    default:           ;
                endcase
            end

            // Results first, so a word taken at this edge never meets its own result.
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with no word waiting for it");
                end
                else
                begin
                    want_word = expected_q.pop_front();
                    check_field("power_on", result.power_on, want_word.power_on);
                    check_field("light_mode", result.light_mode, want_word.light_mode);
                    check_field("sleep_mode", result.sleep_mode, want_word.sleep_mode);
                    check_field("brightness", result.brightness, want_word.brightness);
                    check_field("ramp_up", result.ramp_up, want_word.ramp_up);
                    check_field("status_light", result.status_light,
                                want_word.status_light);
                    check_field("radio_request", result.radio_request,
                                want_word.radio_request);
                    check_field("auto_off", result.auto_off, want_word.auto_off);
                end
                word_no++;
            end

            if (item_valid && !item_stall)
            begin
                predict_word(item, next_word);
                expected_q.push_back(next_word);
            end

            awaiting   <= expected_q.size();
            lamp_is_on <= pwr_on;
        end
    end

endmodule

### verif/lamp_button_mode_controller_top_test.sv
// Testbench top for the lamp panel: clock, reset, register settings, button and tick words, verdict.
`timescale 1ns / 1ps

module lamp_button_mode_controller_top_test;
    import lbmc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    lbmc_in_t               item;
    logic                   result_valid;
    logic                   result_stall;
    lbmc_out_t              result;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatches;
    int                     awaiting;
    logic                   lamp_is_on;
    logic                   calm;
    logic                   squeeze_req;
    int                     words_sent;
    int                     power_long_now;
    int                     light_long_now;

    lamp_button_mode_controller_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lamp_panel_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .lamp_is_on   (lamp_is_on)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one word and hold it until taken, then sometimes pause the sender.
    task automatic offer_word(input lbmc_in_t w);
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    function automatic lbmc_in_t sample_word(input logic p, input logic l, input logic s);
        lbmc_in_t w;
        w.cmd           = CMD_SAMPLE;
        w.power_pressed = p;
        w.light_pressed = l;
        w.sleep_pressed = s;
        return w;
    endfunction

    // Hold a button pattern for n samples, then release everything.
    task automatic hold_buttons(input logic p, input logic l, input logic s, input int n);
        repeat (n) offer_word(sample_word(p, l, s));
        offer_word(sample_word(1'b0, 1'b0, 1'b0));
    endtask

    // Ticks carry random button bits, which the block must ignore.
    task automatic tick_run(input int n);
        lbmc_in_t   w;
        logic [3:0] bits;
        repeat (n)
        begin
            bits  = 4'($urandom_range(0, 15));
            w     = bits;
            w.cmd = CMD_TICK;
            offer_word(w);
        end
    endtask

    // One random gesture: ticks, a timed press, a chord, or loose noise.
    task automatic play_gesture();
        int         n;
        int         short_hi;
        logic [2:0] chord;
        logic [3:0] bits;
        lbmc_in_t   w;
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(90, 140)
                                                : $urandom_range(1, 30);
                tick_run(n);
            end
            3, 4:
            begin
                // Presses around the long-press threshold, up to saturation.
                case ($urandom_range(0, 5))
                    0:       n = 1;
                    1, 2, 3: n = $urandom_range(2, power_long_now);
                    4:       n = power_long_now + 1;
                    default: n = $urandom_range(power_long_now + 1, 64);
                endcase
                hold_buttons(1'b1, 1'b0, 1'b0, n);
            end
            5, 6, 7:
            begin
                short_hi = (light_long_now + 1 < 12) ? light_long_now + 1 : 12;
                case ($urandom_range(0, 9))
                    0:       n = 1;
                    7:       n = light_long_now + 1;
                    8:       n = light_long_now + 2;
                    9:       n = $urandom_range(light_long_now + 2, light_long_now + 8);
                    default: n = $urandom_range(2, short_hi);
                endcase
                hold_buttons(1'b0, 1'b1, 1'b0, n);
            end
            8, 9:
            begin
                case ($urandom_range(0, 7))
                    0:       n = 1;
                    7:       n = $urandom_range(58, 64);
                    default: n = $urandom_range(2, 4);
                endcase
                hold_buttons(1'b0, 1'b0, 1'b1, n);
            end
            10:
            begin
                chord = 3'($urandom_range(1, 7));
                hold_buttons(chord[2], chord[1], chord[0], $urandom_range(1, 12));
            end
            default:
            begin
                repeat ($urandom_range(1, 6))
                begin
                    bits = 4'($urandom_range(0, 15));
                    w    = bits;
                    offer_word(w);
                end
            end
        endcase
    endtask

    task automatic run_gestures(input int upto);
        while (words_sent < upto)
        begin
            play_gesture();
        end
    endtask

    // Stop sending and wait until every result is back and the block has settled.
    task automatic drain_words();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_panel(input logic [7:0] off_short, input logic [7:0] off_long,
                             input logic [7:0] power_long, input logic [7:0] light_long,
                             input logic [7:0] step);
        drain_words();
        write_reg(CFG_OFF_MIN_SHORT, off_short);
        write_reg(CFG_OFF_MIN_LONG, off_long);
        write_reg(CFG_POWER_LONG, power_long);
        write_reg(CFG_LIGHT_LONG, light_long);
        write_reg(CFG_DIM_STEP, step);
        cfg_we <= 1'b0;
        @(posedge clk);
        power_long_now = int'(power_long[5:0]);
        light_long_now = int'(light_long);
    endtask

    // Result side: random stall bursts, one long hold-off on request, none once calm.
    initial
    begin : receiver
        int   run_left;
        logic run_stall;
        logic squeeze_done;
        run_left     = 0;
        run_stall    = 1'b0;
        squeeze_done = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                run_stall = 1'b0;
                run_left  = 0;
            end
            else
            begin
                if (squeeze_req && !squeeze_done)
                begin
                    run_stall    = 1'b1;
                    run_left     = 90;
                    squeeze_done = 1'b1;
                end
                else if (run_left == 0)
                begin
                    run_stall = ($urandom_range(0, 2) == 0);
                    run_left  = run_stall ? $urandom_range(1, 14) : $urandom_range(1, 30);
                end
                run_left--;
            end
            result_stall <= run_stall;
        end
    end

    // Main sequence: directed words, then phases of random gestures under several settings.
    initial
    begin : stimulus
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        calm           = 1'b0;
        squeeze_req    = 1'b0;
        words_sent     = 0;
        power_long_now = 20;
        light_long_now = 10;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle ticks and an empty sample with everything off.
        tick_run(2);
        offer_word(sample_word(1'b0, 1'b0, 1'b0));
        // A press seen on one sample only is ignored.
        hold_buttons(1'b1, 1'b0, 1'b0, 1);
        // Light and sleep presses do nothing while the power is off.
        hold_buttons(1'b0, 1'b1, 1'b0, 2);
        hold_buttons(1'b0, 1'b0, 1'b1, 2);
        // Short power press switches on; light held dims, then steps the mode.
        hold_buttons(1'b1, 1'b0, 1'b0, 3);
        hold_buttons(1'b0, 1'b1, 1'b0, 3);
        // Sleep press selects the short timer and clears the clock.
        hold_buttons(1'b0, 1'b0, 1'b1, 2);
        // All three buttons together on one sample.
        hold_buttons(1'b1, 1'b1, 1'b1, 1);
        tick_run(1);
        run_gestures(240);

        // Low extremes: timers expire at once, long light press is cheap, steepest ramp.
        set_panel(8'd0, 8'd0, 8'd60, 8'd1, 8'd255);
        run_gestures(480);

        // Make sure the lamp is on before power presses all turn long.
        drain_words();
        if (!lamp_is_on)
        begin
            hold_buttons(1'b1, 1'b0, 1'b0, 3);
        end
        drain_words();
        for (int k = 0; k < 3; k++)
        begin
            write_reg(CFG_SPARE_FIRST + 3'(k), 8'($urandom_range(0, 255)));
        end
        cfg_we <= 1'b0;
        @(posedge clk);

        // High extremes, with one long hold-off on the result side.
        set_panel(8'd255, 8'd255, 8'd1, 8'd254, 8'd1);
        squeeze_req = 1'b1;
        run_gestures(720);

        // Random settings; the power threshold carries junk in its upper bits.
        set_panel(8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
                  {2'($urandom_range(0, 3)), 6'($urandom_range(1, 60))},
                  8'($urandom_range(1, 40)), 8'($urandom_range(1, 255)));
        run_gestures(960);
        set_panel(8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
                  {2'($urandom_range(0, 3)), 6'($urandom_range(1, 60))},
                  8'($urandom_range(1, 40)), 8'($urandom_range(1, 255)));
        run_gestures(1080);
        calm = 1'b1;
        run_gestures(1200);

        drain_words();
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Give up if the run hangs.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
